### src/parachute_release_sequencer_macros.svh
// Assertion macros shared by the sequencer RTL.
// Each macro expects signals named clk and rst in the scope of use.
`ifndef PARACHUTE_RELEASE_SEQUENCER_MACROS_SVH
`define PARACHUTE_RELEASE_SEQUENCER_MACROS_SVH

// Checks a consequent in the same cycle as its antecedent.
`define PRS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define PRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/prs_pkg.sv
package prs_pkg;

  localparam int PADDR_W = 5;

  typedef enum logic {
    OP_UPDATE  = 1'b0,
    OP_COMMAND = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    FS_DISARM = 2'd0,
    FS_ARM    = 2'd1,
    FS_KEEP   = 2'd2,
    FS_CLEAR  = 2'd3
  } failsafe_code_e;

  typedef enum logic [1:0] {
    SET_OFF  = 2'd0,
    SET_ON   = 2'd1,
    SET_KEEP = 2'd2
  } set_code_e;

  typedef enum logic [2:0] {
    REG_BLOCK_ENABLED      = 3'd0,
    REG_GIMBAL_DOWN_PWM    = 3'd1,
    REG_GIMBAL_UP_PWM      = 3'd2,
    REG_FAILSAFE_HEIGHT_M  = 3'd3,
    REG_RELEASE_DELAY_MS   = 3'd4,
    REG_TOGGLE_TRIES       = 3'd5,
    REG_TOGGLE_INTERVAL_MS = 3'd6
  } reg_idx_e;

  localparam logic signed [13:0] GIMBAL_SLEW      = 14'sd10;
  localparam logic [11:0]        RESET_GIMBAL_PWM = 12'd1500;
  localparam logic [21:0]        CM_PER_M         = 22'd100;

  typedef struct packed {
    logic        opcode;
    logic [31:0] now_ms;
    logic signed [31:0] altitude_cm;
    logic [1:0]  failsafe_code;
    logic        release_request;
    logic [1:0]  ignition_code;
    logic [1:0]  servo_code;
  } req_t;

  typedef struct packed {
    logic        ignition_live;
    logic        chute_open;
    logic [11:0] gimbal_pwm;
    logic        released;
    logic        release_pending;
  } rsp_t;

  typedef struct packed {
    logic        block_enabled;
    logic [10:0] gimbal_down_pwm;
    logic [10:0] gimbal_up_pwm;
    logic [14:0] failsafe_height_m;
    logic [15:0] release_delay_ms;
    logic [7:0]  toggle_tries;
    logic [14:0] toggle_interval_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    block_enabled:      1'b0,
    gimbal_down_pwm:    11'd1000,
    gimbal_up_pwm:      11'd2000,
    failsafe_height_m:  15'd100,
    release_delay_ms:   16'd2000,
    toggle_tries:       8'd3,
    toggle_interval_ms: 15'd1000
  };

  typedef struct packed {
    logic        failsafe_armed;
    logic        is_released;
    logic        is_pending;
    logic [31:0] release_start_ms;
    logic [31:0] last_toggle_ms;
    logic [7:0]  tries_left;
    logic        ignition_state;
    logic        servo_state;
    logic [11:0] gimbal_target_pwm;
    logic [11:0] gimbal_last_pwm;
    logic        gimbal_is_up;
  } state_t;

  localparam state_t STATE_RESET = '{
    failsafe_armed:    1'b0,
    is_released:       1'b0,
    is_pending:        1'b0,
    release_start_ms:  32'd0,
    last_toggle_ms:    32'd0,
    tries_left:        8'd0,
    ignition_state:    1'b0,
    servo_state:       1'b0,
    gimbal_target_pwm: RESET_GIMBAL_PWM,
    gimbal_last_pwm:   RESET_GIMBAL_PWM,
    gimbal_is_up:      1'b0
  };

endpackage

### src/prs_req_if.sv
interface prs_req_if;
  import prs_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/prs_rsp_if.sv
interface prs_rsp_if;
  import prs_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/parachute_release_sequencer.sv
// Parachute release sequencer.
// Items enter on req (valid/ready) and each one yields exactly one result item
// on rsp, which reports ignition, chute servo, gimbal pulse width, released
// and pending as they stand after that item.
// An item is first held in an input register; once the result register is
// free or being taken, the sequencer state and the result register are
// updated from it, and the result is offered on rsp until rsp takes it.
// The state update is a single pass of short logic, so one item is accepted
// in every cycle for as long as rsp takes results.
// When rsp stalls, the result register holds its item, the input register
// holds the following one, and req.ready falls until rsp takes again.
// Settings are written through the APB port (register i at byte address 4*i,
// pready always high) and should only be changed while no item is in flight.
// Reset clears both pipeline registers, returns every setting to its default
// and puts the sequencer in the disarmed, closed, gimbal-down state with the
// gimbal pulse width at 1500.
`include "parachute_release_sequencer_macros.svh"

module parachute_release_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  prs_req_if.sink                     req,
  prs_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import prs_pkg::*;

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  req_t   stage_q;
  logic   stage_vld;
  rsp_t   rsp_q;
  logic   rsp_vld;
  logic   advance;
  logic   fire;
  logic signed [13:0] slew_diff;

  prs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  prs_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (stage_q),
    .state_next (state_next)
  );

  assign advance   = !rsp_vld || rsp.ready;
  assign fire      = stage_vld && advance;
  assign req.ready = !stage_vld || advance;
  assign rsp.valid = rsp_vld;
  assign rsp.data  = rsp_q;
  assign slew_diff = $signed({2'b00, state_next.gimbal_last_pwm})
                   - $signed({2'b00, state.gimbal_last_pwm});

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= 1'b0;
      rsp_vld   <= 1'b0;
      state     <= STATE_RESET;
    end else begin
      if (req.ready) begin
        stage_vld <= req.valid;
      end
      if (fire) begin
        state   <= state_next;
        rsp_vld <= 1'b1;
      end else if (rsp.ready) begin
        rsp_vld <= 1'b0;
      end
    end
    if (req.ready) begin
      stage_q <= req.data;
    end
    if (fire) begin
      rsp_q.ignition_live   <= state_next.ignition_state;
      rsp_q.chute_open      <= state_next.servo_state;
      rsp_q.gimbal_pwm      <= state_next.gimbal_last_pwm;
      rsp_q.released        <= state_next.is_released;
      rsp_q.release_pending <= state_next.is_pending;
    end
  end

  `PRS_ASSERT_SAME(a_gimbal_slew, fire,
    (slew_diff <= GIMBAL_SLEW) && (slew_diff >= -GIMBAL_SLEW),
    "gimbal slewed by more than the limit")
  `PRS_ASSERT_NEXT(a_disabled_hold,
    fire && (opcode_e'(stage_q.opcode) == OP_UPDATE) && !cfg.block_enabled,
    $stable(state), "state changed on a disabled update")
  `PRS_ASSERT_NEXT(a_stage_hold, stage_vld && !advance,
    stage_vld && $stable(stage_q), "stalled input item was lost or changed")
  `PRS_ASSERT_NEXT(a_result_follows, fire,
    rsp_vld && (rsp_q.gimbal_pwm == state.gimbal_last_pwm),
    "result does not match the updated state")

endmodule

### src/prs_regs.sv
module prs_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prs_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output prs_pkg::cfg_t                 cfg
);
  import prs_pkg::*;

  reg_idx_e reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BLOCK_ENABLED:      cfg.block_enabled      <= pwdata[0];
        REG_GIMBAL_DOWN_PWM:    cfg.gimbal_down_pwm    <= pwdata[10:0];
        REG_GIMBAL_UP_PWM:      cfg.gimbal_up_pwm      <= pwdata[10:0];
        REG_FAILSAFE_HEIGHT_M:  cfg.failsafe_height_m  <= pwdata[14:0];
        REG_RELEASE_DELAY_MS:   cfg.release_delay_ms   <= pwdata[15:0];
        REG_TOGGLE_TRIES:       cfg.toggle_tries       <= pwdata[7:0];
        REG_TOGGLE_INTERVAL_MS: cfg.toggle_interval_ms <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BLOCK_ENABLED:      prdata = {31'd0, cfg.block_enabled};
      REG_GIMBAL_DOWN_PWM:    prdata = {21'd0, cfg.gimbal_down_pwm};
      REG_GIMBAL_UP_PWM:      prdata = {21'd0, cfg.gimbal_up_pwm};
      REG_FAILSAFE_HEIGHT_M:  prdata = {17'd0, cfg.failsafe_height_m};
      REG_RELEASE_DELAY_MS:   prdata = {16'd0, cfg.release_delay_ms};
      REG_TOGGLE_TRIES:       prdata = {24'd0, cfg.toggle_tries};
      REG_TOGGLE_INTERVAL_MS: prdata = {17'd0, cfg.toggle_interval_ms};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

### src/prs_step.sv
module prs_step (
  input  prs_pkg::cfg_t   cfg,
  input  prs_pkg::state_t state,
  input  prs_pkg::req_t   item,
  output prs_pkg::state_t state_next
);
  import prs_pkg::*;

  state_t             s;
  logic [15:0]        since_start;
  logic [15:0]        since_toggle;
  logic [21:0]        floor_cm;
  logic signed [32:0] floor_ext;
  logic signed [32:0] alt_ext;
  logic signed [13:0] lo;
  logic signed [13:0] hi;
  logic signed [13:0] g;

  assign floor_cm  = 22'(cfg.failsafe_height_m) * CM_PER_M;
  assign floor_ext = $signed({11'd0, floor_cm});
  assign alt_ext   = $signed({item.altitude_cm[31], item.altitude_cm});

  always_comb begin
    s            = state;
    since_start  = 16'd0;
    since_toggle = 16'd0;
    lo           = 14'sd0;
    hi           = 14'sd0;
    g            = 14'sd0;
    if (opcode_e'(item.opcode) == OP_COMMAND) begin
      case (failsafe_code_e'(item.failsafe_code))
        FS_CLEAR: begin
          s.is_released      = 1'b0;
          s.is_pending       = 1'b0;
          s.release_start_ms = 32'd0;
          s.tries_left       = 8'd0;
        end
        FS_DISARM: s.failsafe_armed = 1'b0;
        FS_ARM:    s.failsafe_armed = 1'b1;
        default: ;
      endcase
      if (item.release_request) begin
        s.tries_left       = cfg.toggle_tries;
        s.release_start_ms = item.now_ms;
        s.is_pending       = 1'b1;
      end
      case (set_code_e'(item.ignition_code))
        SET_OFF: s.ignition_state = 1'b0;
        SET_ON:  s.ignition_state = 1'b1;
        default: ;
      endcase
      case (set_code_e'(item.servo_code))
        SET_OFF: s.servo_state = 1'b0;
        SET_ON:  s.servo_state = 1'b1;
        default: ;
      endcase
    end else if (cfg.block_enabled) begin
      if (!s.is_released && !s.is_pending && s.failsafe_armed && (floor_ext > alt_ext)) begin
        s.tries_left       = cfg.toggle_tries;
        s.release_start_ms = item.now_ms;
        s.is_pending       = 1'b1;
      end
      if (s.is_pending) begin
        s.ignition_state    = 1'b0;
        s.gimbal_is_up      = 1'b1;
        s.gimbal_target_pwm = {1'b0, cfg.gimbal_up_pwm};
        since_start         = 16'(item.now_ms - s.release_start_ms);
        if (since_start > cfg.release_delay_ms) begin
          s.is_released    = 1'b1;
          s.is_pending     = 1'b0;
          s.last_toggle_ms = item.now_ms;
        end
      end
      if (s.is_released) begin
        since_toggle = 16'(item.now_ms - s.last_toggle_ms);
        if (s.tries_left != 8'd0) begin
          if (!since_toggle[15] && (since_toggle >= {1'b0, cfg.toggle_interval_ms})) begin
            if (s.servo_state) begin
              s.servo_state = 1'b0;
              s.tries_left  = s.tries_left - 8'd1;
            end else begin
              s.servo_state = 1'b1;
            end
            s.last_toggle_ms = item.now_ms;
          end
        end else begin
          s.servo_state = 1'b1;
        end
      end
      lo = $signed({2'b00, s.gimbal_last_pwm}) - GIMBAL_SLEW;
      hi = $signed({2'b00, s.gimbal_last_pwm}) + GIMBAL_SLEW;
      g  = $signed({2'b00, s.gimbal_target_pwm});
      if (g < lo) begin
        g = lo;
      end
      if (g > hi) begin
        g = hi;
      end
      s.gimbal_last_pwm   = g[11:0];
      s.gimbal_target_pwm = s.gimbal_is_up ? {1'b0, cfg.gimbal_up_pwm}
                                           : {1'b0, cfg.gimbal_down_pwm};
    end
    state_next = s;
  end

endmodule
